// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the fade engine RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define RPF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpf assertion failed");

// Next-cycle implication, disabled while in reset
`define RPF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpf assertion failed");

`endif

// File: rtl/core/rpf_pkg.sv
// ----------------------------------------------------------------------------
// rpf_pkg
// Shared types, codes and constants of the RGB555 palette fade engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpf_pkg;

    localparam int CH_W     = 5;
    localparam int NUM_CH   = 3;
    localparam int COLOR_W  = CH_W * NUM_CH;
    localparam int LEVEL_W  = 5;
    localparam int DELAY_W  = 7;
    localparam int WAIT_W   = 6;
    localparam int STEP_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = COLOR_W;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 5'h10;
    localparam logic [LEVEL_W-1:0] END_LEVEL_RST = 5'h10;
    localparam logic [STEP_W-1:0]  STEP_BASE     = 7'd2;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_TICK  = 2'd1,
        OP_BLEND = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET      = 2'd0,
        CFG_START_LEVEL = 2'd1,
        CFG_END_LEVEL   = 2'd2,
        CFG_FADE_DELAY  = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [COLOR_W-1:0]        target_color;
        logic [LEVEL_W-1:0]        start_level;
        logic [LEVEL_W-1:0]        end_level;
        logic signed [DELAY_W-1:0] fade_delay;
    } t_fade_cfg;

    typedef struct packed {
        logic               applied;
        logic [LEVEL_W-1:0] blend_level;
        logic               busy;
    } t_fade_status;

endpackage

`default_nettype wire

// File: rtl/core/rpf_cfg_regs.sv
// ----------------------------------------------------------------------------
// rpf_cfg_regs
// Configuration register file: target colour, start/end level, fade delay.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpf_cfg_regs
    import rpf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_fade_cfg                  o_cfg
);

    t_fade_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_color <= '0;
            r_cfg.start_level  <= '0;
            r_cfg.end_level    <= END_LEVEL_RST;
            r_cfg.fade_delay   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_TARGET:      r_cfg.target_color <= i_cfg_data[COLOR_W-1:0];
                CFG_START_LEVEL: r_cfg.start_level  <= i_cfg_data[LEVEL_W-1:0];
                CFG_END_LEVEL:   r_cfg.end_level    <= i_cfg_data[LEVEL_W-1:0];
                CFG_FADE_DELAY:  r_cfg.fade_delay   <= i_cfg_data[DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/core/rpf_fade_ctrl.sv
// ----------------------------------------------------------------------------
// rpf_fade_ctrl
// Fade level sequencer: start, wait ticks, step and clamp toward end level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpf_fade_ctrl
    import rpf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire logic [1:0]         i_opcode,
    input  t_fade_cfg               i_cfg,
    output logic [LEVEL_W-1:0]      o_blend_level,
    output t_fade_status            o_status
);

    logic [LEVEL_W-1:0] r_cur,   n_cur;
    logic [LEVEL_W-1:0] r_blend, n_blend;
    logic [WAIT_W-1:0]  r_wait,  n_wait;
    logic               r_active, n_active;
    logic [STEP_W-1:0]  r_step,  n_step;
    logic [WAIT_W-1:0]  r_wlim,  n_wlim;
    logic [LEVEL_W-1:0] r_end,   n_end;
    logic               r_down,  n_down;

    logic               do_apply;
    logic [LEVEL_W-1:0] a_cur;
    logic [LEVEL_W-1:0] a_end;
    logic [STEP_W-1:0]  a_step;
    logic               a_down;
    logic [STEP_W:0]    up_sum;
    logic [STEP_W:0]    dn_lim;
    logic [LEVEL_W-1:0] stepped;
    logic [LEVEL_W-1:0] start_clamped;
    logic [LEVEL_W-1:0] end_clamped;

    assign start_clamped = (i_cfg.start_level > LEVEL_MAX) ? LEVEL_MAX : i_cfg.start_level;
    assign end_clamped   = (i_cfg.end_level > LEVEL_MAX) ? LEVEL_MAX : i_cfg.end_level;

    always_comb begin
        n_cur    = r_cur;
        n_blend  = r_blend;
        n_wait   = r_wait;
        n_active = r_active;
        n_step   = r_step;
        n_wlim   = r_wlim;
        n_end    = r_end;
        n_down   = r_down;
        do_apply = 1'b0;

        case (t_opcode'(i_opcode))
            OP_START: begin
                if (i_cfg.fade_delay[DELAY_W-1]) begin
                    n_step = ~i_cfg.fade_delay + STEP_W'(3);
                    n_wlim = '0;
                end else begin
                    n_step = STEP_BASE;
                    n_wlim = i_cfg.fade_delay[WAIT_W-1:0];
                end
                n_wait   = n_wlim;
                n_cur    = start_clamped;
                n_end    = end_clamped;
                n_down   = !(start_clamped < end_clamped);
                do_apply = 1'b1;
            end
            OP_TICK: begin
                if (r_active) begin
                    if (r_wait < r_wlim) begin
                        n_wait = r_wait + WAIT_W'(1);
                    end else begin
                        n_wait   = '0;
                        do_apply = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        a_cur  = (t_opcode'(i_opcode) == OP_START) ? start_clamped : r_cur;
        a_end  = n_end;
        a_step = n_step;
        a_down = n_down;

        up_sum = {3'b000, a_cur} + {1'b0, a_step};
        dn_lim = {1'b0, a_step} + {3'b000, a_end};
        if (!a_down) begin
            stepped = (up_sum > {3'b000, a_end}) ? a_end : up_sum[LEVEL_W-1:0];
        end else begin
            stepped = ({3'b000, a_cur} < dn_lim) ? a_end : (a_cur - a_step[LEVEL_W-1:0]);
        end

        if (do_apply) begin
            n_blend = a_cur;
            if (a_cur == a_end) begin
                n_active = 1'b0;
            end else begin
                n_cur = stepped;
            end
            if (t_opcode'(i_opcode) == OP_START) begin
                n_active = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= '0;
            r_blend  <= '0;
            r_wait   <= '0;
            r_active <= 1'b0;
            r_step   <= '0;
            r_wlim   <= '0;
            r_end    <= '0;
            r_down   <= 1'b0;
        end else if (i_fire) begin
            r_cur    <= n_cur;
            r_blend  <= n_blend;
            r_wait   <= n_wait;
            r_active <= n_active;
            r_step   <= n_step;
            r_wlim   <= n_wlim;
            r_end    <= n_end;
            r_down   <= n_down;
        end
    end

    assign o_blend_level        = r_blend;
    assign o_status.applied     = do_apply;
    assign o_status.blend_level = n_blend;
    assign o_status.busy        = n_active;

endmodule

`default_nettype wire

// File: rtl/core/rpf_blend.sv
// ----------------------------------------------------------------------------
// rpf_blend
// Per-channel linear mix of a colour toward the target at a level in 1/16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpf_blend
    import rpf_pkg::*;
(
    input  wire logic [COLOR_W-1:0] i_color,
    input  wire logic [COLOR_W-1:0] i_target,
    input  wire logic [LEVEL_W-1:0] i_level,
    output logic [COLOR_W-1:0]      o_color
);

    for (genvar k = 0; k < NUM_CH; k++) begin : g_ch
        logic [CH_W-1:0]             c;
        logic [CH_W-1:0]             t;
        logic signed [CH_W:0]        diff;
        logic signed [2*CH_W+1:0]    prod;
        logic signed [2*CH_W+1:0]    shifted;

        assign c       = i_color[k*CH_W +: CH_W];
        assign t       = i_target[k*CH_W +: CH_W];
        assign diff    = $signed({1'b0, t}) - $signed({1'b0, c});
        assign prod    = diff * $signed({1'b0, i_level});
        assign shifted = prod >>> 4;
        assign o_color[k*CH_W +: CH_W] = c + shifted[CH_W-1:0];
    end

endmodule

`default_nettype wire

// File: rtl/core/rgb555_palette_fade_engine.sv
// ----------------------------------------------------------------------------
// rgb555_palette_fade_engine
// Top level: input register, fade sequencer, colour blend, result register.
// ----------------------------------------------------------------------------
// Takes one word per cycle while the output side is ready and returns one
// result word per input word through the input and result registers, a rate
// set by the single input register feeding the fade sequencer and three 6x6
// channel multipliers ahead of the result register. The user must write the
// configuration only while no word is in flight; the block does not check it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rgb555_palette_fade_engine
    import rpf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [1:0]            i_opcode,
    input  wire logic [COLOR_W-1:0]    i_color_in,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [COLOR_W-1:0]         o_color_out,
    output logic                       o_applied,
    output logic [LEVEL_W-1:0]         o_blend_level_out,
    output logic                       o_busy_res
);

    t_fade_cfg          cfg;
    t_fade_status       status;
    logic [LEVEL_W-1:0] cur_blend_level;
    logic [COLOR_W-1:0] blended;

    logic               r_s1_valid;
    logic [1:0]         r_s1_opcode;
    logic [COLOR_W-1:0] r_s1_color;

    logic               r_out_valid;
    logic [COLOR_W-1:0] r_color_out;
    logic               r_applied;
    logic [LEVEL_W-1:0] r_blend_level;
    logic               r_busy;

    logic               out_free;
    logic               s1_fire;
    logic               in_fire;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_fire    = i_in_valid && o_in_ready;

    rpf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rpf_fade_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (s1_fire),
        .i_opcode      (r_s1_opcode),
        .i_cfg         (cfg),
        .o_blend_level (cur_blend_level),
        .o_status      (status)
    );

    rpf_blend u_blend (
        .i_color  (r_s1_color),
        .i_target (cfg.target_color),
        .i_level  (cur_blend_level),
        .o_color  (blended)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_opcode <= i_opcode;
            r_s1_color  <= i_color_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_color_out   <= (t_opcode'(r_s1_opcode) == OP_BLEND) ? blended : '0;
            r_applied     <= status.applied;
            r_blend_level <= status.blend_level;
            r_busy        <= status.busy;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_color_out       = r_color_out;
    assign o_applied         = r_applied;
    assign o_blend_level_out = r_blend_level;
    assign o_busy_res        = r_busy;

    `RPF_ASSERT_NXT(a_out_held, i_clk, i_rst_n, r_out_valid && !i_out_ready, r_out_valid)
    `RPF_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !o_in_ready,
                    r_s1_valid && r_out_valid && !i_out_ready)
    `RPF_ASSERT_IMP(a_blend_no_apply, i_clk, i_rst_n, o_out_valid && (o_color_out != '0),
                    !o_applied)
    `RPF_ASSERT_IMP(a_level_range, i_clk, i_rst_n, o_out_valid, o_blend_level_out <= LEVEL_MAX)

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB555 palette fade engine.
// ----------------------------------------------------------------------------
// A directed table covers reset behaviour, level and delay extremes, a start
// at the end level, an idle tick and the unused opcode. Random phases follow:
// each rewrites the four registers while idle, then streams starts, ticks,
// blends and no-ops with random gaps on both sides. A local fade model
// predicts results the table lacks; each accepted word is checked per field.
// ----------------------------------------------------------------------------

module tb;
    import rpf_pkg::*;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               applied;
        logic [LEVEL_W-1:0] level;
        logic               busy;
    } t_fade_result;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_WORD,
        ROW_KNOWN
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        t_opcode               op;
        t_cfg_index            reg_idx;
        logic [CFG_DATA_W-1:0] data;
        t_fade_result          res;
    } t_dir_row;

    localparam int N_DIR    = 35;
    localparam int N_PHASES = 16;
    localparam int N_PER    = 100;
    localparam int MAX_IDLE = 17;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [1:0]            i_opcode;
    logic [COLOR_W-1:0]    i_color_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [COLOR_W-1:0]    o_color_out;
    logic                  o_applied;
    logic [LEVEL_W-1:0]    o_blend_level_out;
    logic                  o_busy_res;

    rgb555_palette_fade_engine u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_opcode          (i_opcode),
        .i_color_in        (i_color_in),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_color_out       (o_color_out),
        .o_applied         (o_applied),
        .o_blend_level_out (o_blend_level_out),
        .o_busy_res        (o_busy_res)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #15_000_000;
        $display("tb: failure");
        $finish;
    end

    // fade model: register copies and sequencer state
    logic [COLOR_W-1:0]        target_reg;
    logic [LEVEL_W-1:0]        start_level_reg;
    logic [LEVEL_W-1:0]        end_level_reg;
    logic signed [DELAY_W-1:0] fade_delay_reg;
    int                        cur_level;
    int                        blend_lvl;
    int                        wait_cnt;
    bit                        fading;
    int                        run_step;
    int                        run_wait;
    int                        run_end;
    bit                        run_down;

    t_fade_result blends_due[$];
    int           n_fail;
    bit           tx_gaps_on;
    bit           rx_stalls_on;

    t_dir_row directed_rows [0:N_DIR-1] = '{
        '{ROW_KNOWN, OP_BLEND, CFG_TARGET, 15'h7fff, '{15'h7fff, 1'b0, 5'd0, 1'b0}},
        '{ROW_KNOWN, OP_BLEND, CFG_TARGET, 15'h0000, '{15'h0000, 1'b0, 5'd0, 1'b0}},
        '{ROW_KNOWN, OP_TICK, CFG_TARGET, 15'h7fff, '{15'h0000, 1'b0, 5'd0, 1'b0}},
        '{ROW_KNOWN, OP_NOP, CFG_TARGET, 15'h5555, '{15'h0000, 1'b0, 5'd0, 1'b0}},
        '{ROW_CFG, OP_NOP, CFG_TARGET, 15'h7fff, '0},
        '{ROW_CFG, OP_NOP, CFG_START_LEVEL, 15'h0010, '0},
        '{ROW_KNOWN, OP_START, CFG_TARGET, 15'h0000, '{15'h0000, 1'b1, 5'd16, 1'b1}},
        '{ROW_KNOWN, OP_BLEND, CFG_TARGET, 15'h0000, '{15'h7fff, 1'b0, 5'd16, 1'b1}},
        '{ROW_KNOWN, OP_TICK, CFG_TARGET, 15'h0000, '{15'h0000, 1'b1, 5'd16, 1'b0}},
        '{ROW_KNOWN, OP_TICK, CFG_TARGET, 15'h0000, '{15'h0000, 1'b0, 5'd16, 1'b0}},
        '{ROW_CFG, OP_NOP, CFG_START_LEVEL, 15'h0000, '0},
        '{ROW_CFG, OP_NOP, CFG_END_LEVEL, 15'h001f, '0},
        '{ROW_CFG, OP_NOP, CFG_FADE_DELAY, 15'h0040, '0},
        '{ROW_KNOWN, OP_START, CFG_TARGET, 15'h7fff, '{15'h0000, 1'b1, 5'd0, 1'b1}},
        '{ROW_KNOWN, OP_BLEND, CFG_TARGET, 15'h2a55, '{15'h2a55, 1'b0, 5'd0, 1'b1}},
        '{ROW_KNOWN, OP_TICK, CFG_TARGET, 15'h0000, '{15'h0000, 1'b1, 5'd16, 1'b0}},
        '{ROW_CFG, OP_NOP, CFG_START_LEVEL, 15'h001f, '0},
        '{ROW_CFG, OP_NOP, CFG_END_LEVEL, 15'h0000, '0},
        '{ROW_CFG, OP_NOP, CFG_FADE_DELAY, 15'h003f, '0},
        '{ROW_KNOWN, OP_START, CFG_TARGET, 15'h0000, '{15'h0000, 1'b1, 5'd16, 1'b1}},
        '{ROW_KNOWN, OP_TICK, CFG_TARGET, 15'h0000, '{15'h0000, 1'b1, 5'd14, 1'b1}},
        '{ROW_KNOWN, OP_TICK, CFG_TARGET, 15'h0000, '{15'h0000, 1'b0, 5'd14, 1'b1}},
        '{ROW_WORD, OP_BLEND, CFG_TARGET, 15'h4210, '0},
        '{ROW_CFG, OP_NOP, CFG_TARGET, 15'h0000, '0},
        '{ROW_CFG, OP_NOP, CFG_FADE_DELAY, 15'h0073, '0},
        '{ROW_WORD, OP_BLEND, CFG_TARGET, 15'h7fff, '0},
        '{ROW_WORD, OP_START, CFG_TARGET, 15'h0000, '0},
        '{ROW_WORD, OP_TICK, CFG_TARGET, 15'h0000, '0},
        '{ROW_WORD, OP_TICK, CFG_TARGET, 15'h0000, '0},
        '{ROW_WORD, OP_BLEND, CFG_TARGET, 15'h1234, '0},
        '{ROW_CFG, OP_NOP, CFG_START_LEVEL, 15'h0008, '0},
        '{ROW_CFG, OP_NOP, CFG_END_LEVEL, 15'h0008, '0},
        '{ROW_WORD, OP_START, CFG_TARGET, 15'h0000, '0},
        '{ROW_WORD, OP_TICK, CFG_TARGET, 15'h0000, '0},
        '{ROW_WORD, OP_BLEND, CFG_TARGET, 15'h7c1f, '0}
    };

    function automatic int sat_level(logic [LEVEL_W-1:0] v);
        return (v > 16) ? 16 : int'(v);
    endfunction

    function automatic void step_level();
        int nxt;
        blend_lvl = cur_level;
        if (cur_level == run_end) begin
            fading = 1'b0;
        end else begin
            nxt = run_down ? cur_level - run_step : cur_level + run_step;
            if (!run_down && nxt > run_end) nxt = run_end;
            if (run_down && nxt < run_end) nxt = run_end;
            cur_level = nxt;
        end
    endfunction

    function automatic t_fade_result fade_predict(t_opcode op, logic [COLOR_W-1:0] cin);
        t_fade_result r;
        int           dly;
        int           src;
        int           tgt;
        int           mix;
        r   = '0;
        dly = fade_delay_reg;
        case (op)
            OP_START: begin
                if (dly < 0) begin
                    run_step = 2 - dly;
                    run_wait = 0;
                end else begin
                    run_step = 2;
                    run_wait = dly;
                end
                wait_cnt  = run_wait;
                cur_level = sat_level(start_level_reg);
                run_end   = sat_level(end_level_reg);
                run_down  = !(cur_level < run_end);
                step_level();
                fading    = 1'b1;
                r.applied = 1'b1;
            end
            OP_TICK: begin
                if (fading) begin
                    if (wait_cnt < run_wait) begin
                        wait_cnt++;
                    end else begin
                        wait_cnt  = 0;
                        step_level();
                        r.applied = 1'b1;
                    end
                end
            end
            OP_BLEND: begin
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    src = cin[CH_W*ch +: CH_W];
                    tgt = target_reg[CH_W*ch +: CH_W];
                    mix = src + (((tgt - src) * blend_lvl) >>> 4);
                    r.color[CH_W*ch +: CH_W] = mix[CH_W-1:0];
                end
            end
            default: ;
        endcase
        r.level = blend_lvl[LEVEL_W-1:0];
        r.busy  = fading;
        return r;
    endfunction

    task automatic write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_TARGET:      target_reg      = data[COLOR_W-1:0];
            CFG_START_LEVEL: start_level_reg = data[LEVEL_W-1:0];
            CFG_END_LEVEL:   end_level_reg   = data[LEVEL_W-1:0];
            CFG_FADE_DELAY:  fade_delay_reg  = data[DELAY_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_word(t_opcode op, logic [COLOR_W-1:0] cin, bit known,
                             t_fade_result typed);
        int           gap;
        t_fade_result r;
        gap = tx_gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_color_in <= cin;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = fade_predict(op, cin);
        blends_due.push_back(known ? typed : r);
    endtask

    // drop valid and hold until every result word is back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (blends_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        t_fade_result got;
        t_fade_result want;
        int           stall;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = rx_stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            got = '{o_color_out, o_applied, o_blend_level_out, o_busy_res};
            if (blends_due.size() == 0) begin
                $error("unexpected result word: color_out %h", got.color);
                n_fail++;
            end else begin
                want = blends_due.pop_front();
                if (got.color !== want.color) begin
                    $error("color_out: expected %h, got %h", want.color, got.color);
                    n_fail++;
                end
                if (got.applied !== want.applied) begin
                    $error("applied: expected %b, got %b", want.applied, got.applied);
                    n_fail++;
                end
                if (got.level !== want.level) begin
                    $error("blend_level_out: expected %0d, got %0d", want.level, got.level);
                    n_fail++;
                end
                if (got.busy !== want.busy) begin
                    $error("busy_res: expected %b, got %b", want.busy, got.busy);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        bit                    cfg_open;
        int                    base;
        int                    lv;
        int                    dl;
        int                    pick;
        logic [CFG_DATA_W-1:0] junk;
        logic [CFG_DATA_W-1:0] v_tgt;
        logic [CFG_DATA_W-1:0] v_st;
        logic [CFG_DATA_W-1:0] v_en;
        logic [CFG_DATA_W-1:0] v_dl;
        logic [CFG_DATA_W-1:0] cin;
        t_cfg_index            idx;
        t_opcode               op;

        n_fail          = 0;
        tx_gaps_on      = 1'b1;
        rx_stalls_on    = 1'b1;
        target_reg      = '0;
        start_level_reg = '0;
        end_level_reg   = END_LEVEL_RST;
        fade_delay_reg  = '0;
        cur_level       = 0;
        blend_lvl       = 0;
        wait_cnt        = 0;
        fading          = 1'b0;
        run_step        = 0;
        run_wait        = 0;
        run_end         = 0;
        run_down        = 1'b0;
        cfg_open        = 1'b0;

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_opcode    <= OP_NOP;
        i_color_in  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < N_DIR; n++) begin
            if (directed_rows[n].kind == ROW_CFG) begin
                if (!cfg_open) begin
                    drain();
                    cfg_open = 1'b1;
                end
                write_reg(directed_rows[n].reg_idx, directed_rows[n].data);
            end else begin
                if (cfg_open) begin
                    i_cfg_we <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_word(directed_rows[n].op, directed_rows[n].data,
                          directed_rows[n].kind == ROW_KNOWN, directed_rows[n].res);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            tx_gaps_on   = $urandom_range(0, 3) != 0;
            rx_stalls_on = $urandom_range(0, 3) != 0;
            case (ph)
                0: begin
                    v_tgt = 15'h7fff; v_st = 15'h0000; v_en = 15'h0010; v_dl = 15'h0040;
                end
                1: begin
                    v_tgt = 15'h0000; v_st = 15'h0010; v_en = 15'h0000; v_dl = 15'h003f;
                end
                2: begin
                    v_tgt = 15'h7fff; v_st = 15'h001f; v_en = 15'h001f; v_dl = 15'h0073;
                end
                default: begin
                    v_tgt = CFG_DATA_W'($urandom_range(0, 32767));
                    junk  = CFG_DATA_W'(($urandom_range(0, 3) == 0) ?
                                        $urandom_range(0, 32767) : 0);
                    lv    = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31)
                                                         : $urandom_range(0, 16);
                    v_st  = (junk & 15'h7fe0) | CFG_DATA_W'(lv[LEVEL_W-1:0]);
                    lv    = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31)
                                                         : $urandom_range(0, 16);
                    v_en  = (junk & 15'h7fe0) | CFG_DATA_W'(lv[LEVEL_W-1:0]);
                    pick  = $urandom_range(0, 9);
                    if (pick < 4)      dl = -$urandom_range(1, 13);
                    else if (pick < 8) dl = $urandom_range(0, 6);
                    else if (pick < 9) dl = $urandom_range(7, 63);
                    else               dl = -$urandom_range(14, 64);
                    v_dl  = (junk & 15'h7f80) | CFG_DATA_W'(dl[DELAY_W-1:0]);
                end
            endcase
            base = $urandom_range(0, 3);
            for (int k = 0; k < 4; k++) begin
                idx = t_cfg_index'((base + k) % 4);
                case (idx)
                    CFG_TARGET:      write_reg(idx, v_tgt);
                    CFG_START_LEVEL: write_reg(idx, v_st);
                    CFG_END_LEVEL:   write_reg(idx, v_en);
                    default:         write_reg(idx, v_dl);
                endcase
            end
            i_cfg_we <= 1'b0;

            for (int n = 0; n < N_PER; n++) begin
                if ((ph == 1 && n == N_PER / 2) || $urandom_range(0, 199) == 0) drain();
                pick = $urandom_range(0, 99);
                if (pick < 6)       op = OP_START;
                else if (pick < 55) op = OP_TICK;
                else if (pick < 94) op = OP_BLEND;
                else                op = OP_NOP;
                pick = $urandom_range(0, 19);
                if (pick == 0)      cin = 15'h0000;
                else if (pick == 1) cin = 15'h7fff;
                else                cin = CFG_DATA_W'($urandom_range(0, 32767));
                send_word(op, cin, 1'b0, '0);
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/rpf_pkg.sv
rtl/core/rpf_cfg_regs.sv
rtl/core/rpf_fade_ctrl.sv
rtl/core/rpf_blend.sv
rtl/core/rgb555_palette_fade_engine.sv
test/tb.sv
